### rtl/sgc_pkg.sv
// Shared types and constants for the two-axis stepper ramp and goto controller.
`default_nettype none
package sgc_pkg;

	localparam int TIMER_LIMIT = 65536;
	localparam int DIV_NW = 33;
	localparam int DIV_DW = 16;
	localparam int DIV_CW = 6;
	localparam int PADDR_W = 5;

	localparam int F_EN = 0;
	localparam int F_DIS = 1;
	localparam int F_DIR = 2;
	localparam int F_GOTO = 3;
	localparam int F_ADJ = 4;
	localparam int F_SLOW = 5;
	localparam int F_PULSE = 6;

	localparam logic [1:0] STS_OK = 2'd0;
	localparam logic [1:0] STS_BUSY = 2'd1;
	localparam logic [1:0] STS_NOINIT = 2'd2;
	localparam logic [1:0] STS_INVALID = 2'd3;

	localparam logic [2:0] REG_MAX_RATE = 3'd0;
	localparam logic [2:0] REG_MAX_ACCEL = 3'd1;
	localparam logic [2:0] REG_SID_PSC = 3'd2;
	localparam logic [2:0] REG_SID_PER = 3'd3;
	localparam logic [2:0] REG_USTEP_SHIFT = 3'd4;
	localparam logic [2:0] REG_REVERSE = 3'd5;

	typedef enum logic [3:0] {
		OP_TICK = 4'd0,
		OP_ENABLE_SET = 4'd1,
		OP_SET_POS = 4'd2,
		OP_SLEW = 4'd3,
		OP_GOTO = 4'd4,
		OP_STOP = 4'd5,
		OP_DISABLE = 4'd6,
		OP_TRACK = 4'd7,
		OP_READ = 4'd8
	} op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LOAD,
		S_EXEC,
		S_BATCH,
		S_GMOD,
		S_ADJ,
		S_PSTART,
		S_PDIV,
		S_NORM,
		S_SETB,
		S_BDIV,
		S_NDIV,
		S_POST,
		S_OUT
	} state_t;

	typedef struct packed {
		logic [15:0] max_rate;
		logic [15:0] max_accel;
		logic [16:0] sid_psc;
		logic [16:0] sid_per;
		logic [3:0] ustep_shift;
		logic [1:0] reverse;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		max_rate: 16'd800,
		max_accel: 16'd16,
		sid_psc: 17'd1,
		sid_per: 17'd65536,
		ustep_shift: 4'd4,
		reverse: 2'd0
	};

	typedef struct packed {
		logic [31:0] pos;
		logic [7:0] period;
		logic [7:0] remain;
		logic [15:0] target;
		logic [15:0] present;
		logic [31:0] csp;
		logic [31:0] lap;
		logic [31:0] start;
		logic [31:0] slow;
		logic [31:0] tgt;
		logic [6:0] flags;
		logic [16:0] psc;
		logic [16:0] reload;
	} axis_rec_t;

	localparam axis_rec_t REC_RESET = '{
		pos: 32'd0,
		period: 8'd1,
		remain: 8'd1,
		target: 16'd1,
		present: 16'd0,
		csp: 32'd0,
		lap: 32'd0,
		start: 32'd0,
		slow: 32'd0,
		tgt: 32'd0,
		flags: 7'd0,
		psc: 17'd1,
		reload: 17'd1
	};

endpackage
`default_nettype wire

### rtl/sgc_regs.sv
// APB configuration register file.
`default_nettype none
module sgc_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [sgc_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [31:0]                   pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	output sgc_pkg::cfg_t                      cfg
);

	sgc_pkg::cfg_t cfg_q;
	logic [2:0] idx;
	logic wr;

	assign idx = paddr[4:2];
	assign wr = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= sgc_pkg::CFG_RESET;
		end else if (wr) begin
			unique case (idx)
				sgc_pkg::REG_MAX_RATE: cfg_q.max_rate <= pwdata[15:0];
				sgc_pkg::REG_MAX_ACCEL: cfg_q.max_accel <= pwdata[15:0];
				sgc_pkg::REG_SID_PSC: cfg_q.sid_psc <= pwdata[16:0];
				sgc_pkg::REG_SID_PER: cfg_q.sid_per <= pwdata[16:0];
				sgc_pkg::REG_USTEP_SHIFT: cfg_q.ustep_shift <= pwdata[3:0];
				sgc_pkg::REG_REVERSE: cfg_q.reverse <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			sgc_pkg::REG_MAX_RATE: prdata = {16'd0, cfg_q.max_rate};
			sgc_pkg::REG_MAX_ACCEL: prdata = {16'd0, cfg_q.max_accel};
			sgc_pkg::REG_SID_PSC: prdata = {15'd0, cfg_q.sid_psc};
			sgc_pkg::REG_SID_PER: prdata = {15'd0, cfg_q.sid_per};
			sgc_pkg::REG_USTEP_SHIFT: prdata = {28'd0, cfg_q.ustep_shift};
			sgc_pkg::REG_REVERSE: prdata = {30'd0, cfg_q.reverse};
			default: prdata = 32'd0;
		endcase
	end

endmodule
`default_nettype wire

### rtl/sgc_div.sv
// Serial restoring divider, one quotient bit per cycle.
`default_nettype none
module sgc_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [sgc_pkg::DIV_NW-1:0]   dividend,
	input  wire logic [sgc_pkg::DIV_DW-1:0]   divisor,
	output logic                              done,
	output logic [sgc_pkg::DIV_NW-1:0]        quotient,
	output logic [sgc_pkg::DIV_DW-1:0]        remainder
);

	logic [sgc_pkg::DIV_NW-1:0] quo_q;
	logic [sgc_pkg::DIV_DW-1:0] rem_q;
	logic [sgc_pkg::DIV_DW-1:0] dvs_q;
	logic [sgc_pkg::DIV_CW-1:0] cnt_q;
	logic run_q;
	logic done_q;
	logic [sgc_pkg::DIV_DW:0] trial;
	logic [sgc_pkg::DIV_DW:0] diff;
	logic ge;

	assign trial = {rem_q, quo_q[sgc_pkg::DIV_NW-1]};
	assign diff = trial - {1'b0, dvs_q};
	assign ge = trial >= {1'b0, dvs_q};
	assign done = done_q;
	assign quotient = quo_q;
	assign remainder = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= sgc_pkg::DIV_CW'(sgc_pkg::DIV_NW - 1);
			end else if (run_q) begin
				if (cnt_q == '0) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[sgc_pkg::DIV_NW-2:0], ge};
			rem_q <= ge ? diff[sgc_pkg::DIV_DW-1:0] : trial[sgc_pkg::DIV_DW-1:0];
		end
	end

endmodule
`default_nettype wire

### rtl/sgc_mem.sv
// Per-axis state memory with registered synchronous read, unwritten entries read as reset.
`default_nettype none
module sgc_mem #(
	parameter int DEPTH = 2,
	parameter int AW = 1
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   rd_en,
	input  wire logic [AW-1:0]          rd_addr,
	output sgc_pkg::axis_rec_t          rd_data,
	input  wire logic                   wr_en,
	input  wire logic [AW-1:0]          wr_addr,
	input  sgc_pkg::axis_rec_t          wr_data
);

	sgc_pkg::axis_rec_t mem_q [DEPTH];
	sgc_pkg::axis_rec_t rd_q;
	logic [DEPTH-1:0] valid_q;
	logic rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_q : sgc_pkg::REC_RESET;

endmodule
`default_nettype wire

### rtl/stepper_ramp_goto_controller.sv
// Top level: command sequencer for the two-axis stepper ramp and goto controller.
// Without a rate change a transaction passes S_LOAD, S_EXEC and S_OUT, and done is registered from S_OUT.
// A rate change adds up to four passes through the shared serial divider and the S_NORM normalize loop;
// the receiver cannot stall.
// One transaction at a time: busy stays high until the result strobe.
// Reset clears control and configuration; axis records read as reset values until written.
`default_nettype none
module stepper_ramp_goto_controller #(
	parameter int AXES = 2,
	parameter int MAX_BATCH = 128
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [3:0]                    opcode,
	input  wire logic                          axis,
	input  wire logic                          direction,
	input  wire logic [15:0]                   rate,
	input  wire logic [22:0]                   step_count,
	input  wire logic [23:0]                   full_step_position,
	input  wire logic [16:0]                   first_divider,
	input  wire logic [16:0]                   second_divider,
	output logic                               done,
	output logic [1:0]                         status,
	output logic [31:0]                        position,
	output logic                               enabled,
	output logic                               running,
	output logic                               moving_direction,
	output logic                               direction_pin,
	output logic [15:0]                        current_rate,
	output logic [16:0]                        timer_prescaler,
	output logic [16:0]                        timer_reload,
	output logic                               pulse_enable,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [sgc_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [31:0]                   pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);

	localparam int AW = (AXES > 1) ? $clog2(AXES) : 1;

	function automatic logic [16:0] clamp17(input logic [16:0] v);
		if (v == 17'd0) return 17'd1;
		if (v > 17'(sgc_pkg::TIMER_LIMIT)) return 17'(sgc_pkg::TIMER_LIMIT);
		return v;
	endfunction

	function automatic logic [31:0] partial(input sgc_pkg::axis_rec_t s);
		logic [7:0] p;
		p = (s.remain <= s.period) ? (s.period - s.remain) : 8'd0;
		return s.flags[sgc_pkg::F_DIR] ? (32'd0 - 32'(p)) : 32'(p);
	endfunction

	function automatic logic reached(input sgc_pkg::axis_rec_t s, input logic [31:0] x);
		return s.flags[sgc_pkg::F_DIR] ? (s.pos <= x) : (s.pos >= x);
	endfunction

	sgc_pkg::cfg_t cfg;
	sgc_pkg::state_t state_q, state_d;
	sgc_pkg::axis_rec_t w_q, w_d, rd_data;
	sgc_pkg::op_t op_q;
	logic a_q, a_c, dir_q;
	logic [15:0] rate_in_q;
	logic [22:0] cnt_q;
	logic [23:0] fsp_q;
	logic [16:0] d1_q, d2_q;
	logic [1:0] sts_q, sts_d;
	logic start_flag_q, start_flag_d;
	logic [15:0] rate_q, rate_d;
	logic [15:0] raw_q, raw_d;
	logic [32:0] prod_q, prod_d;
	logic [32:0] arr_q, arr_d;
	logic [16:0] psc_q, psc_d;
	logic neg_q, neg_d;
	logic [31:0] mag_q, mag_d;
	logic div_start, div_done;
	logic [sgc_pkg::DIV_NW-1:0] div_a, div_q;
	logic [sgc_pkg::DIV_DW-1:0] div_b, div_r;
	logic done_q;
	logic [1:0] status_q;
	logic [31:0] position_q;
	logic enabled_q, running_q, mdir_q, dpin_q, pulse_q;
	logic [15:0] crate_q;
	logic [16:0] tpsc_q, trel_q;

	logic [15:0] eff_max, eff_acc;
	logic [16:0] psc_c, per_c, d1_c, d2_c;
	logic [31:0] part_w, u_v, mag_v, m_v, d_v, n_v, pos_o;
	logic signed [17:0] dlt, accs;
	logic [16:0] nr;
	logic [15:0] nr_c;
	logic [7:0] b_v;
	logic en_w, fwd_w;

	sgc_regs u_regs (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
	);

	sgc_mem #(.DEPTH(AXES), .AW(AW)) u_mem (
		.clk(clk), .arst_n(arst_n),
		.rd_en(state_q == sgc_pkg::S_IDLE && start), .rd_addr(AW'(a_c)), .rd_data(rd_data),
		.wr_en(state_q == sgc_pkg::S_OUT), .wr_addr(AW'(a_q)), .wr_data(w_q)
	);

	sgc_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_a), .divisor(div_b),
		.done(div_done), .quotient(div_q), .remainder(div_r)
	);

	assign a_c = (AXES > 1) ? axis : 1'b0;
	assign busy = state_q != sgc_pkg::S_IDLE;

	assign eff_max = (cfg.max_rate == 16'd0) ? 16'd1 : cfg.max_rate;
	assign eff_acc = (cfg.max_accel == 16'd0) ? 16'd1 : cfg.max_accel;
	assign psc_c = clamp17(cfg.sid_psc);
	assign per_c = clamp17(cfg.sid_per);
	assign d1_c = clamp17(d1_q);
	assign d2_c = clamp17(d2_q);
	assign part_w = partial(w_q);
	assign en_w = w_q.flags[sgc_pkg::F_EN];
	assign fwd_w = !w_q.flags[sgc_pkg::F_DIR];

	assign u_v = (w_q.slow << 1) - w_q.lap - w_q.pos;
	assign mag_v = u_v[31] ? (32'd0 - u_v) : u_v;
	assign m_v = mag_q - 32'(div_r);
	assign d_v = neg_q ? (32'd0 - m_v) : m_v;
	assign n_v = 32'(raw_q) - 32'(div_r);
	assign pos_o = (w_q.pos + ((w_q.present != 16'd0) ? part_w : 32'd0)) >> cfg.ustep_shift;

	assign dlt = $signed({2'b00, w_q.target}) - $signed({2'b00, w_q.present});
	assign accs = $signed({2'b00, eff_acc});
	always_comb begin
		if (dlt > accs) begin
			nr = {1'b0, w_q.present} + {1'b0, eff_acc};
		end else if (dlt < -accs) begin
			nr = {1'b0, w_q.present} - {1'b0, eff_acc};
		end else begin
			nr = {1'b0, w_q.target};
		end
	end
	assign nr_c = (nr[15:0] > eff_max) ? eff_max : nr[15:0];

	always_comb begin
		if (div_q == '0) begin
			b_v = 8'd1;
		end else if (div_q > 33'(MAX_BATCH)) begin
			b_v = 8'(MAX_BATCH);
		end else begin
			b_v = div_q[7:0];
		end
	end

	always_comb begin
		state_d = state_q;
		w_d = w_q;
		sts_d = sts_q;
		start_flag_d = start_flag_q;
		rate_d = rate_q;
		raw_d = raw_q;
		prod_d = prod_q;
		arr_d = arr_q;
		psc_d = psc_q;
		neg_d = neg_q;
		mag_d = mag_q;
		div_start = 1'b0;
		div_a = '0;
		div_b = '0;
		unique case (state_q)
			sgc_pkg::S_IDLE: begin
				if (start) state_d = sgc_pkg::S_LOAD;
			end
			sgc_pkg::S_LOAD: begin
				w_d = rd_data;
				state_d = sgc_pkg::S_EXEC;
			end
			sgc_pkg::S_EXEC: begin
				sts_d = sgc_pkg::STS_OK;
				start_flag_d = 1'b0;
				state_d = sgc_pkg::S_OUT;
				unique case (op_q)
					sgc_pkg::OP_TICK: begin
						if (w_q.flags[sgc_pkg::F_PULSE]) begin
							if (w_q.remain <= 8'd1) begin
								w_d.remain = w_q.period;
								w_d.pos = fwd_w ? w_q.pos + 32'(w_q.period)
									: w_q.pos - 32'(w_q.period);
								state_d = sgc_pkg::S_BATCH;
							end else begin
								w_d.remain = w_q.remain - 8'd1;
							end
						end
					end
					sgc_pkg::OP_ENABLE_SET: begin
						if (w_q.present != 16'd0) begin
							sts_d = sgc_pkg::STS_BUSY;
						end else begin
							w_d.pos = 32'(fsp_q) << cfg.ustep_shift;
							w_d.flags[sgc_pkg::F_EN] = 1'b1;
						end
					end
					sgc_pkg::OP_SET_POS: begin
						if (w_q.present != 16'd0) begin
							sts_d = sgc_pkg::STS_BUSY;
						end else if (!en_w) begin
							sts_d = sgc_pkg::STS_NOINIT;
						end else begin
							w_d.pos = 32'(fsp_q) << cfg.ustep_shift;
						end
					end
					sgc_pkg::OP_SLEW: begin
						if (!en_w) begin
							sts_d = sgc_pkg::STS_NOINIT;
						end else if (w_q.present != 16'd0
								&& w_q.flags[sgc_pkg::F_DIR] != dir_q) begin
							sts_d = sgc_pkg::STS_BUSY;
						end else begin
							w_d.flags[sgc_pkg::F_DIR] = dir_q;
							w_d.target = (rate_in_q <= eff_max) ? rate_in_q : eff_max;
							start_flag_d = 1'b1;
							state_d = sgc_pkg::S_ADJ;
						end
					end
					sgc_pkg::OP_GOTO: begin
						if (!en_w) begin
							sts_d = sgc_pkg::STS_NOINIT;
						end else if (w_q.present != 16'd0) begin
							sts_d = sgc_pkg::STS_BUSY;
						end else if (cnt_q == 23'd0) begin
							sts_d = sgc_pkg::STS_INVALID;
						end else begin
							mag_d = 32'(cnt_q) << cfg.ustep_shift;
							w_d.start = w_q.pos;
							w_d.tgt = dir_q ? w_q.pos - mag_d : w_q.pos + mag_d;
							w_d.slow = dir_q ? w_q.pos - (mag_d >> 1) : w_q.pos + (mag_d >> 1);
							w_d.flags[sgc_pkg::F_ADJ] = 1'b0;
							w_d.flags[sgc_pkg::F_SLOW] = 1'b0;
							w_d.flags[sgc_pkg::F_DIR] = dir_q;
							w_d.flags[sgc_pkg::F_GOTO] = 1'b1;
							w_d.target = eff_max;
							start_flag_d = 1'b1;
							state_d = sgc_pkg::S_ADJ;
						end
					end
					sgc_pkg::OP_STOP: begin
						w_d.flags[sgc_pkg::F_GOTO] = 1'b0;
						w_d.target = 16'd0;
						state_d = sgc_pkg::S_ADJ;
					end
					sgc_pkg::OP_DISABLE: begin
						w_d.flags[sgc_pkg::F_DIS] = 1'b0;
						if (w_q.present != 16'd0) begin
							w_d.flags[sgc_pkg::F_DIS] = 1'b1;
							w_d.flags[sgc_pkg::F_GOTO] = 1'b0;
							w_d.target = 16'd0;
							state_d = sgc_pkg::S_ADJ;
						end else begin
							w_d.flags[sgc_pkg::F_EN] = 1'b0;
						end
					end
					sgc_pkg::OP_TRACK: begin
						if (!en_w) begin
							sts_d = sgc_pkg::STS_NOINIT;
						end else if (w_q.present > 16'd1) begin
							sts_d = sgc_pkg::STS_BUSY;
						end else begin
							if (d1_c > 17'd1) begin
								w_d.reload = d1_c;
								w_d.psc = d2_c;
							end else begin
								w_d.reload = d2_c;
								w_d.psc = d1_c;
							end
							w_d.flags[sgc_pkg::F_DIR] = dir_q;
							w_d.target = 16'd1;
							if (w_q.present == 16'd0) begin
								w_d.period = 8'd1;
								if (!w_q.flags[sgc_pkg::F_PULSE]) begin
									w_d.flags[sgc_pkg::F_PULSE] = 1'b1;
									w_d.remain = 8'd1;
								end
							end
							w_d.present = 16'd1;
						end
					end
					sgc_pkg::OP_READ: ;
					default: sts_d = sgc_pkg::STS_INVALID;
				endcase
			end
			sgc_pkg::S_BATCH: begin
				state_d = sgc_pkg::S_OUT;
				if (w_q.flags[sgc_pkg::F_GOTO] && reached(w_q, w_q.tgt)) begin
					w_d.flags[sgc_pkg::F_GOTO] = 1'b0;
					w_d.target = 16'd0;
					state_d = sgc_pkg::S_ADJ;
				end else if (w_q.flags[sgc_pkg::F_GOTO] && !w_q.flags[sgc_pkg::F_SLOW]
						&& reached(w_q, w_q.slow)) begin
					if (!w_q.flags[sgc_pkg::F_ADJ]) begin
						w_d.flags[sgc_pkg::F_ADJ] = 1'b1;
						neg_d = u_v[31];
						mag_d = mag_v;
						div_start = 1'b1;
						div_a = {1'b0, mag_v};
						div_b = {8'd0, w_q.period};
						state_d = sgc_pkg::S_GMOD;
					end else begin
						w_d.flags[sgc_pkg::F_SLOW] = 1'b1;
						w_d.target = eff_acc;
						state_d = sgc_pkg::S_ADJ;
					end
				end else begin
					if (w_q.flags[sgc_pkg::F_GOTO] && !w_q.flags[sgc_pkg::F_ADJ]
							&& w_q.present == w_q.target) begin
						w_d.slow = w_q.tgt - (w_q.pos - w_q.start);
						w_d.flags[sgc_pkg::F_ADJ] = 1'b1;
					end
					if (w_q.present != w_q.target && reached(w_q, w_q.csp)) begin
						state_d = sgc_pkg::S_ADJ;
					end
				end
			end
			sgc_pkg::S_GMOD: begin
				if (div_done) begin
					if (d_v != 32'd0) begin
						w_d.slow = w_q.pos + d_v;
						w_d.csp = w_q.pos + d_v;
						state_d = sgc_pkg::S_OUT;
					end else begin
						w_d.flags[sgc_pkg::F_SLOW] = 1'b1;
						w_d.target = eff_acc;
						state_d = sgc_pkg::S_ADJ;
					end
				end
			end
			sgc_pkg::S_ADJ: begin
				if (nr == 17'd0) begin
					w_d.target = 16'd0;
					w_d.present = 16'd0;
					w_d.csp = 32'd0;
					w_d.flags[sgc_pkg::F_PULSE] = 1'b0;
					w_d.pos = w_q.pos + part_w;
					w_d.period = 8'd1;
					w_d.remain = 8'd1;
					if (w_q.flags[sgc_pkg::F_DIS]) begin
						w_d.flags[sgc_pkg::F_DIS] = 1'b0;
						w_d.flags[sgc_pkg::F_EN] = 1'b0;
					end
					state_d = sgc_pkg::S_POST;
				end else begin
					rate_d = nr_c;
					raw_d = nr[15:0];
					prod_d = 33'(psc_c) * 33'(per_c);
					if (nr_c == 16'd1) begin
						w_d.psc = psc_c;
						w_d.reload = per_c;
						state_d = sgc_pkg::S_SETB;
					end else begin
						state_d = sgc_pkg::S_PSTART;
					end
				end
			end
			sgc_pkg::S_PSTART: begin
				div_start = 1'b1;
				div_a = prod_q;
				div_b = rate_q;
				state_d = sgc_pkg::S_PDIV;
			end
			sgc_pkg::S_PDIV: begin
				if (div_done) begin
					arr_d = div_q;
					psc_d = 17'd1;
					state_d = sgc_pkg::S_NORM;
				end
			end
			sgc_pkg::S_NORM: begin
				if (arr_q > 33'(sgc_pkg::TIMER_LIMIT)) begin
					arr_d = arr_q >> 1;
					psc_d = psc_q << 1;
				end else begin
					w_d.psc = psc_q;
					w_d.reload = (arr_q == 33'd0) ? 17'd1 : arr_q[16:0];
					state_d = sgc_pkg::S_SETB;
				end
			end
			sgc_pkg::S_SETB: begin
				w_d.pos = w_q.pos + part_w;
				div_start = 1'b1;
				div_a = 33'(rate_q);
				div_b = eff_acc;
				state_d = sgc_pkg::S_BDIV;
			end
			sgc_pkg::S_BDIV: begin
				if (div_done) begin
					w_d.period = b_v;
					w_d.remain = b_v;
					w_d.present = rate_q;
					w_d.lap = w_q.pos;
					div_start = 1'b1;
					div_a = 33'(raw_q);
					div_b = {8'd0, b_v};
					state_d = sgc_pkg::S_NDIV;
				end
			end
			sgc_pkg::S_NDIV: begin
				if (div_done) begin
					w_d.csp = fwd_w ? w_q.pos + n_v : w_q.pos - n_v;
					state_d = sgc_pkg::S_POST;
				end
			end
			sgc_pkg::S_POST: begin
				if (start_flag_q && !w_q.flags[sgc_pkg::F_PULSE] && w_q.present != 16'd0) begin
					w_d.flags[sgc_pkg::F_PULSE] = 1'b1;
					w_d.remain = w_q.period;
				end
				state_d = sgc_pkg::S_OUT;
			end
			sgc_pkg::S_OUT: begin
				state_d = sgc_pkg::S_IDLE;
			end
			default: state_d = sgc_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sgc_pkg::S_IDLE;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= state_q == sgc_pkg::S_OUT;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == sgc_pkg::S_IDLE && start) begin
			op_q <= sgc_pkg::op_t'(opcode);
			a_q <= a_c;
			dir_q <= direction;
			rate_in_q <= rate;
			cnt_q <= step_count;
			fsp_q <= full_step_position;
			d1_q <= first_divider;
			d2_q <= second_divider;
		end
		w_q <= w_d;
		sts_q <= sts_d;
		start_flag_q <= start_flag_d;
		rate_q <= rate_d;
		raw_q <= raw_d;
		prod_q <= prod_d;
		arr_q <= arr_d;
		psc_q <= psc_d;
		neg_q <= neg_d;
		mag_q <= mag_d;
		if (state_q == sgc_pkg::S_OUT) begin
			status_q <= sts_q;
			position_q <= pos_o;
			enabled_q <= w_q.flags[sgc_pkg::F_EN];
			running_q <= w_q.present != 16'd0;
			mdir_q <= w_q.flags[sgc_pkg::F_DIR];
			dpin_q <= w_q.flags[sgc_pkg::F_DIR] ^ cfg.reverse[a_q];
			crate_q <= w_q.present;
			tpsc_q <= w_q.psc;
			trel_q <= w_q.reload;
			pulse_q <= w_q.flags[sgc_pkg::F_PULSE];
		end
	end

	assign done = done_q;
	assign status = status_q;
	assign position = position_q;
	assign enabled = enabled_q;
	assign running = running_q;
	assign moving_direction = mdir_q;
	assign direction_pin = dpin_q;
	assign current_rate = crate_q;
	assign timer_prescaler = tpsc_q;
	assign timer_reload = trel_q;
	assign pulse_enable = pulse_q;

	a_done_after_out: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == sgc_pkg::S_OUT))
		else $error("result strobe without a finished transaction");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not raise busy");

	a_running_rate: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (running == (current_rate != 16'd0)))
		else $error("running flag disagrees with rate");

	a_timer_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (timer_reload != 17'd0 && timer_prescaler != 17'd0))
		else $error("zero timer setting");

endmodule
`default_nettype wire
